// ----- hw/rtl/bms_pkg.sv -----
// shared types, constants and note lookups for the button melody sequencer
`default_nettype none

package bms_pkg;

    localparam int MAX_NOTES  = 16;
    localparam int IDX_W      = $clog2(MAX_NOTES);
    localparam int ENTRY_IDX_W = 4;
    localparam int POS_W      = 5;
    localparam int COUNT_W    = 8;
    localparam int CODE_W     = 8;
    localparam int NLEN_W     = 8;
    localparam int HZ_W       = 10;
    localparam int CMP_W      = 16;
    localparam int PERIOD_W   = 16;
    localparam int MLEN_W     = 5;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [PERIOD_W-1:0] STEP_PERIOD_RST   = 16'd100;
    localparam logic [MLEN_W-1:0]   MELODY_LENGTH_RST = 5'd11;
    localparam logic [CMP_W-1:0]    CMP_SILENT        = 16'hFFFF;

    // note codes
    localparam logic [CODE_W-1:0] NOTE_C      = 8'h43;
    localparam logic [CODE_W-1:0] NOTE_D      = 8'h44;
    localparam logic [CODE_W-1:0] NOTE_E      = 8'h45;
    localparam logic [CODE_W-1:0] NOTE_F      = 8'h46;
    localparam logic [CODE_W-1:0] NOTE_G      = 8'h47;
    localparam logic [CODE_W-1:0] NOTE_A      = 8'h41;
    localparam logic [CODE_W-1:0] NOTE_B      = 8'h42;
    localparam logic [CODE_W-1:0] NOTE_HIGH_C = 8'h08;

    // tone frequencies in whole hertz
    localparam logic [HZ_W-1:0] HZ_SILENT = 10'd0;
    localparam logic [HZ_W-1:0] HZ_C      = 10'd261;
    localparam logic [HZ_W-1:0] HZ_D      = 10'd293;
    localparam logic [HZ_W-1:0] HZ_E      = 10'd329;
    localparam logic [HZ_W-1:0] HZ_F      = 10'd349;
    localparam logic [HZ_W-1:0] HZ_G      = 10'd392;
    localparam logic [HZ_W-1:0] HZ_A      = 10'd440;
    localparam logic [HZ_W-1:0] HZ_B      = 10'd493;
    localparam logic [HZ_W-1:0] HZ_HIGH_C = 10'd523;

    typedef enum logic [2:0] {
        PH_START   = 3'd0,
        PH_IDLE    = 3'd1,
        PH_PLAY    = 3'd2,
        PH_ADVANCE = 3'd3,
        PH_WAIT    = 3'd4
    } phase_t;

    typedef enum logic [0:0] {
        MODE_TICK  = 1'b0,
        MODE_WRITE = 1'b1
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STEP_PERIOD   = 1'b0,
        CFG_MELODY_LENGTH = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic                   mode;
        logic                   button;
        logic [ENTRY_IDX_W-1:0] entry_index;
        logic [CODE_W-1:0]      entry_note;
        logic [NLEN_W-1:0]      entry_length;
    } item_t;

    typedef struct packed {
        logic              tone_on;
        logic [HZ_W-1:0]   tone_hz;
        logic [CMP_W-1:0]  compare_value;
        logic              step_taken;
        logic [2:0]        phase;
    } res_t;

    // unknown codes keep the tone already sounding
    function automatic logic [HZ_W-1:0] tone_for(
        input logic [CODE_W-1:0] code,
        input logic [HZ_W-1:0]   keep
    );
        logic [HZ_W-1:0] hz;
        unique case (code)
            NOTE_C:      hz = HZ_C;
            NOTE_D:      hz = HZ_D;
            NOTE_E:      hz = HZ_E;
            NOTE_F:      hz = HZ_F;
            NOTE_G:      hz = HZ_G;
            NOTE_A:      hz = HZ_A;
            NOTE_B:      hz = HZ_B;
            NOTE_HIGH_C: hz = HZ_HIGH_C;
            default:     hz = keep;
        endcase
        return hz;
    endfunction

    // 62500 / hz - 1 for the tones in use (8 MHz clock, prescale 128)
    function automatic logic [CMP_W-1:0] compare_for(input logic [HZ_W-1:0] hz);
        logic [CMP_W-1:0] cmp;
        unique case (hz)
            HZ_C:      cmp = 16'd238;
            HZ_D:      cmp = 16'd212;
            HZ_E:      cmp = 16'd188;
            HZ_F:      cmp = 16'd178;
            HZ_G:      cmp = 16'd158;
            HZ_A:      cmp = 16'd141;
            HZ_B:      cmp = 16'd125;
            HZ_HIGH_C: cmp = 16'd118;
            default:   cmp = CMP_SILENT;
        endcase
        return cmp;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/bms_if.sv -----
// valid/ready channels carrying command items and status items
`default_nettype none

interface bms_cmd_if;
    logic                           valid;
    logic                           ready;
    logic                           mode;
    logic                           button;
    logic [bms_pkg::ENTRY_IDX_W-1:0] entry_index;
    logic [bms_pkg::CODE_W-1:0]     entry_note;
    logic [bms_pkg::NLEN_W-1:0]     entry_length;

    modport source (output valid, mode, button, entry_index, entry_note, entry_length,
                    input ready);
    modport sink   (input valid, mode, button, entry_index, entry_note, entry_length,
                    output ready);
endinterface

interface bms_status_if;
    logic                      valid;
    logic                      ready;
    logic                      tone_on;
    logic [bms_pkg::HZ_W-1:0]  tone_hz;
    logic [bms_pkg::CMP_W-1:0] compare_value;
    logic                      step_taken;
    logic [2:0]                phase;

    modport source (output valid, tone_on, tone_hz, compare_value, step_taken, phase,
                    input ready);
    modport sink   (input valid, tone_on, tone_hz, compare_value, step_taken, phase,
                    output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/bms_core.sv -----
// sequencer state, prescaler, melody table and next-status logic
`default_nettype none

module bms_core (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [bms_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [bms_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire logic                              fire,
    input  wire bms_pkg::item_t                    item,
    output bms_pkg::res_t                          res_next
);

    logic [bms_pkg::PERIOD_W-1:0] period_reg;
    logic [bms_pkg::MLEN_W-1:0]   mlen_reg;
    bms_pkg::phase_t              phase_reg, phase_mid, phase_next;
    logic [bms_pkg::POS_W-1:0]    pos_reg, pos_next;
    logic [bms_pkg::COUNT_W-1:0]  count_reg, count_next;
    logic [bms_pkg::PERIOD_W-1:0] pre_reg, pre_next;
    logic [bms_pkg::HZ_W-1:0]     hz_reg, hz_mid, hz_next;
    logic                         stepped;

    logic [bms_pkg::CODE_W-1:0]   codes_mem [bms_pkg::MAX_NOTES];
    logic [bms_pkg::NLEN_W-1:0]   lengths_mem [bms_pkg::MAX_NOTES];

    logic                         pos_in_table;
    logic [bms_pkg::CODE_W-1:0]   cur_code;
    logic [bms_pkg::NLEN_W-1:0]   cur_len;

    // positions past the table read as code 0, length 0
    assign pos_in_table = (int'(pos_reg) < bms_pkg::MAX_NOTES);
    assign cur_code = pos_in_table ? codes_mem[pos_reg[bms_pkg::IDX_W-1:0]] : '0;
    assign cur_len  = pos_in_table ? lengths_mem[pos_reg[bms_pkg::IDX_W-1:0]] : '0;

    always_comb
    begin
        phase_mid  = phase_reg;
        phase_next = phase_reg;
        hz_mid     = hz_reg;
        hz_next    = hz_reg;
        pos_next   = pos_reg;
        count_next = count_reg;
        pre_next   = pre_reg;
        stepped    = 1'b0;

        if (item.mode == bms_pkg::MODE_WRITE)
        begin
            // table write: sequencer holds
        end
        else if (pre_reg <= bms_pkg::PERIOD_W'(1))
        begin
            pre_next = period_reg;
            stepped  = 1'b1;

            // phase transition
            unique case (phase_reg)
                bms_pkg::PH_START:   phase_mid = bms_pkg::PH_IDLE;
                bms_pkg::PH_IDLE:
                begin
                    if (item.button)
                    begin
                        hz_mid    = bms_pkg::HZ_SILENT;
                        phase_mid = bms_pkg::PH_PLAY;
                    end
                end
                bms_pkg::PH_PLAY:
                    phase_mid = (count_reg < cur_len) ? bms_pkg::PH_PLAY
                                                      : bms_pkg::PH_ADVANCE;
                bms_pkg::PH_ADVANCE:
                begin
                    if (pos_reg < mlen_reg)
                        phase_mid = bms_pkg::PH_PLAY;
                    else
                    begin
                        hz_mid    = bms_pkg::HZ_SILENT;
                        phase_mid = bms_pkg::PH_WAIT;
                    end
                end
                bms_pkg::PH_WAIT:
                begin
                    if (!item.button)
                        phase_mid = bms_pkg::PH_IDLE;
                end
                default:             phase_mid = bms_pkg::PH_START;
            endcase

            // work of the phase just entered
            phase_next = phase_mid;
            hz_next    = hz_mid;
            unique case (phase_mid)
                bms_pkg::PH_IDLE:
                begin
                    pos_next   = '0;
                    count_next = '0;
                end
                bms_pkg::PH_PLAY:
                begin
                    count_next = count_reg + bms_pkg::COUNT_W'(1);
                    hz_next    = bms_pkg::tone_for(cur_code, hz_mid);
                end
                bms_pkg::PH_ADVANCE:
                begin
                    pos_next   = pos_reg + bms_pkg::POS_W'(1);
                    count_next = '0;
                end
                default:
                begin
                end
            endcase
        end
        else
        begin
            pre_next = pre_reg - bms_pkg::PERIOD_W'(1);
        end
    end

    always_comb
    begin
        res_next.tone_on       = (hz_next != bms_pkg::HZ_SILENT);
        res_next.tone_hz       = hz_next;
        res_next.compare_value = bms_pkg::compare_for(hz_next);
        res_next.step_taken    = stepped;
        res_next.phase         = phase_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= bms_pkg::STEP_PERIOD_RST;
            mlen_reg   <= bms_pkg::MELODY_LENGTH_RST;
            phase_reg  <= bms_pkg::PH_START;
            pos_reg    <= '0;
            count_reg  <= '0;
            pre_reg    <= bms_pkg::STEP_PERIOD_RST;
            hz_reg     <= bms_pkg::HZ_SILENT;
        end
        else
        begin
            if (fire)
            begin
                phase_reg <= phase_next;
                pos_reg   <= pos_next;
                count_reg <= count_next;
                hz_reg    <= hz_next;
            end
            // a period write reloads the prescaler
            if (cfg_we && cfg_index == bms_pkg::CFG_STEP_PERIOD)
            begin
                period_reg <= cfg_data[bms_pkg::PERIOD_W-1:0];
                pre_reg    <= cfg_data[bms_pkg::PERIOD_W-1:0];
            end
            else if (fire)
                pre_reg <= pre_next;
            if (cfg_we && cfg_index == bms_pkg::CFG_MELODY_LENGTH)
                mlen_reg <= cfg_data[bms_pkg::MLEN_W-1:0];
        end
    end

    // melody table, contents undefined until written
    always_ff @(posedge clk)
    begin
        if (fire && item.mode == bms_pkg::MODE_WRITE
            && int'(item.entry_index) < bms_pkg::MAX_NOTES)
        begin
            codes_mem[item.entry_index[bms_pkg::IDX_W-1:0]]   <= item.entry_note;
            lengths_mem[item.entry_index[bms_pkg::IDX_W-1:0]] <= item.entry_length;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/button_melody_sequencer.sv -----
// top level of the button melody sequencer: handshake, status register, checks
//
// channel  | dir | payload                                                | role
// ---------+-----+--------------------------------------------------------+---------------------
// cmd      | in  | mode, button, entry_index, entry_note, entry_length    | ms tick or table write
// status   | out | tone_on, tone_hz, compare_value, step_taken, phase     | one item per cmd item
// cfg_*    | in  | cfg_we, cfg_index, cfg_data                            | register writes
//
// one cmd item is taken per cycle unless status stalls; its status item is loaded into the output register
// the whole sequencer step and table read sit between the state and status registers
// cmd.ready stays high while the status register is empty or being drained, so a stall
// on status holds one item and blocks cmd only until it is taken
// reset clears control state; the melody table has no reset and must be written before use
`default_nettype none

module button_melody_sequencer (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    bms_cmd_if.sink                             cmd,
    bms_status_if.source                        status,
    input  wire logic                           cfg_we,
    input  wire logic [bms_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [bms_pkg::CFG_DATA_W-1:0] cfg_data
);

    bms_pkg::item_t item;
    bms_pkg::res_t  res_next;
    bms_pkg::res_t  res_reg;
    logic           out_valid_reg, out_valid_next;
    logic           fire;

    // accept while the status register is empty or being emptied
    assign cmd.ready = !out_valid_reg || status.ready;
    assign fire      = cmd.valid && cmd.ready;

    assign item.mode         = cmd.mode;
    assign item.button       = cmd.button;
    assign item.entry_index  = cmd.entry_index;
    assign item.entry_note   = cmd.entry_note;
    assign item.entry_length = cmd.entry_length;

    bms_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .fire      (fire),
        .item      (item),
        .res_next  (res_next)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (fire)
            out_valid_next = 1'b1;
        else if (status.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    // status payload, loaded with each accepted item
    always_ff @(posedge clk)
    begin
        if (fire)
            res_reg <= res_next;
    end

    assign status.valid         = out_valid_reg;
    assign status.tone_on       = res_reg.tone_on;
    assign status.tone_hz       = res_reg.tone_hz;
    assign status.compare_value = res_reg.compare_value;
    assign status.step_taken    = res_reg.step_taken;
    assign status.phase         = res_reg.phase;

    // a table write never moves the sequencer
    a_write_no_step: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && cmd.mode == bms_pkg::MODE_WRITE) |=> !status.step_taken)
        else $error("table write item reported a step");

    // silence and the compare value agree
    a_silent_compare: assert property (@(posedge clk) disable iff (!rst_n)
        (status.valid && !status.tone_on) |->
            (status.compare_value == bms_pkg::CMP_SILENT && status.tone_hz == '0))
        else $error("silent status with a tone compare value");

    // an empty status register never blocks the command side
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !status.valid |-> cmd.ready)
        else $error("cmd stalled with an empty status register");

    // every accepted item leaves a status item behind
    a_fire_gives_status: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> status.valid)
        else $error("accepted item produced no status item");

endmodule

`default_nettype wire
